/* hw/rtl/euler_angles_to_dcm_core_macros.svh */
// assertion helpers shared by the checker
`ifndef EULER_ANGLES_TO_DCM_CORE_MACROS_SVH
`define EULER_ANGLES_TO_DCM_CORE_MACROS_SVH

// same-cycle implication
`define EADC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("eadc assertion failed");

// next-cycle implication
`define EADC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("eadc assertion failed");

`endif

/* hw/rtl/eadc_pkg.sv */
package eadc_pkg;

   localparam int FIELD_W        = 16;
   localparam int OUT_W          = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int OUT_FRAC_DEF   = 14;
   localparam int ADDR_W         = 4;
   localparam int DATA_W         = 32;
   localparam int LAT_SINCOS     = 17;
   localparam int LATENCY        = LAT_SINCOS + 5;

   localparam logic [1:0] AXIS_X = 2'd1;
   localparam logic [1:0] AXIS_Y = 2'd2;
   localparam logic [1:0] AXIS_Z = 2'd3;

   localparam logic [1:0] REG_FIRST  = 2'd0;
   localparam logic [1:0] REG_SECOND = 2'd1;
   localparam logic [1:0] REG_THIRD  = 2'd2;

   localparam int unsigned SIN_DIV [5] = '{110, 72, 42, 20, 6};
   localparam int unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};

   typedef logic signed [31:0] entry_type;
   typedef entry_type mat_type [9];

   localparam entry_type ONE = 32'sh4000_0000;

   // reciprocal shift for exact floor division of a 30-bit value
   function automatic int div_shift(input int unsigned d);
      int l;
      l = 0;
      for (int i = 0; i < 16; i++) begin
         if ((32'd1 << l) < d) l = l + 1;
      end
      return 30 + l;
   endfunction

   // q60 to q30, ties away from zero
   function automatic entry_type round_q30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] r;
      logic [31:0] rl;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + 64'h2000_0000) >> 30;
      rl  = r[31:0];
      return v[63] ? -rl : rl;
   endfunction

   function automatic mat_type elem_rot(input entry_type s, input entry_type c,
                                        input logic [1:0] axis);
      mat_type m;
      for (int i = 0; i < 9; i++) m[i] = '0;
      unique case (axis)
         AXIS_X: begin
            m[0] = ONE; m[4] = c; m[8] = c; m[5] = s; m[7] = -s;
         end
         AXIS_Y: begin
            m[0] = c; m[2] = -s; m[4] = ONE; m[6] = s; m[8] = c;
         end
         AXIS_Z: begin
            m[0] = c; m[1] = s; m[3] = -s; m[4] = c; m[8] = ONE;
         end
         default: begin
         end
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/eadc_sincos.sv */
module eadc_sincos #(
   parameter int ANGLE_BITS = eadc_pkg::ANGLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic [eadc_pkg::FIELD_W-1:0] angle,
   output eadc_pkg::entry_type          sin_q,
   output eadc_pkg::entry_type          cos_q
);

   localparam logic [32:0] MASK_W = (33'd1 << ANGLE_BITS) - 33'd1;
   localparam logic [31:0] HPI_LO = 32'd2451551556;
   localparam logic [1:0]  QUAD_0 = 2'd0;
   localparam logic [1:0]  QUAD_1 = 2'd1;
   localparam logic [1:0]  QUAD_2 = 2'd2;
   localparam logic [1:0]  QUAD_3 = 2'd3;

   logic [31:0] ext;
   logic [31:0] t;
   logic [30:0] folded;
   logic        fold;
   logic [29:0] r_in;
   logic [62:0] xsum;
   logic [29:0] x2;

   logic [29:0] r1_ff;
   logic [29:0] r2_ff;
   logic [61:0] rm2_ff;
   logic [29:0] x3_ff;
   logic [29:0] x4_ff;
   logic [59:0] xx4_ff;
   logic [2:0]  qs_ff [1:16];
   logic [29:0] xl_ff [1:10];
   logic [29:0] xv_ff [1:10];

   logic [59:0] cpr_ff [6];
   logic [61:0] cqm_ff [6];
   logic [59:0] spr_ff [5];
   logic [61:0] sqm_ff [5];
   logic [59:0] sx_ff;
   logic [29:0] sd_ff;
   logic [30:0] hc [7];
   logic [30:0] hs [6];
   logic [29:0] x2t [6];

   eadc_pkg::entry_type sin_ff, cos_ff, sin_in, cos_in;

   always_comb begin
      ext    = {{(32 - eadc_pkg::FIELD_W){1'b0}}, angle} & MASK_W[31:0];
      t      = ext << (32 - ANGLE_BITS);
      fold   = t[29:0] > 30'h2000_0000;
      folded = 31'h4000_0000 - {1'b0, t[29:0]};
      r_in   = fold ? folded[29:0] : t[29:0];
      xsum   = {1'b0, r2_ff, 32'd0} + {1'b0, rm2_ff} + 63'h8000_0000;
      x2     = xx4_ff[59:30];
   end

   always_ff @(posedge clock) begin
      r1_ff    <= r_in;
      qs_ff[1] <= {fold, t[31:30]};
      rm2_ff   <= 62'(r1_ff) * 62'(HPI_LO);
      r2_ff    <= r1_ff;
      x3_ff    <= xsum[61:32];
      xx4_ff   <= 60'(x3_ff) * 60'(x3_ff);
      x4_ff    <= x3_ff;
      xl_ff[1] <= x2;
      xv_ff[1] <= x4_ff;
      for (int i = 2; i <= 16; i++) qs_ff[i] <= qs_ff[i-1];
      for (int i = 2; i <= 10; i++) begin
         xl_ff[i] <= xl_ff[i-1];
         xv_ff[i] <= xv_ff[i-1];
      end
   end

   assign x2t[0] = x2;
   assign hc[0]  = 31'(eadc_pkg::ONE);
   assign hs[0]  = 31'(eadc_pkg::ONE);

   // horner steps: x2*h, then floor division by reciprocal multiply
   for (genvar j = 0; j < 6; j++) begin : g_cos
      localparam int unsigned DC = eadc_pkg::COS_DIV[j];
      localparam int KC = eadc_pkg::div_shift(DC);
      localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);
      logic [61:0] quo;
      if (j > 0) begin : g_tap
         assign x2t[j] = xl_ff[2*j];
      end
      assign quo       = cqm_ff[j] >> KC;
      assign hc[j+1]   = 31'h4000_0000 - {1'b0, quo[29:0]};
      always_ff @(posedge clock) begin
         cpr_ff[j] <= 60'(x2t[j]) * 60'(hc[j]);
         cqm_ff[j] <= 62'(cpr_ff[j][59:30]) * 62'(MC[31:0]);
      end
   end

   for (genvar j = 0; j < 5; j++) begin : g_sin
      localparam int unsigned DS = eadc_pkg::SIN_DIV[j];
      localparam int KS = eadc_pkg::div_shift(DS);
      localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);
      logic [61:0] quo;
      assign quo     = sqm_ff[j] >> KS;
      assign hs[j+1] = 31'h4000_0000 - {1'b0, quo[29:0]};
      always_ff @(posedge clock) begin
         spr_ff[j] <= 60'(x2t[j]) * 60'(hs[j]);
         sqm_ff[j] <= 62'(spr_ff[j][59:30]) * 62'(MS[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= 60'(xv_ff[10]) * 60'(hs[5]);
      sd_ff <= sx_ff[59:30];
   end

   always_comb begin
      eadc_pkg::entry_type s, c;
      s = qs_ff[16][2] ? 32'(hc[6]) : 32'(sd_ff);
      c = qs_ff[16][2] ? 32'(sd_ff) : 32'(hc[6]);
      unique case (qs_ff[16][1:0])
         QUAD_0: begin sin_in = s;  cos_in = c;  end
         QUAD_1: begin sin_in = c;  cos_in = -s; end
         QUAD_2: begin sin_in = -s; cos_in = -c; end
         QUAD_3: begin sin_in = -c; cos_in = s;  end
      endcase
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

/* hw/rtl/eadc_matmul.sv */
module eadc_matmul (
   input  logic              clock,
   input  eadc_pkg::mat_type a,
   input  eadc_pkg::mat_type b,
   output eadc_pkg::mat_type p
);

   logic signed [63:0] pr_ff [9][3];
   eadc_pkg::mat_type  p_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pr_ff[i*3+j][k] <= 64'(a[i*3+k]) * 64'(b[k*3+j]);
            end
         end
      end
      for (int n = 0; n < 9; n++) begin
         p_ff[n] <= eadc_pkg::round_q30(pr_ff[n][0] + pr_ff[n][1] + pr_ff[n][2]);
      end
   end

   assign p = p_ff;

endmodule

/* hw/rtl/euler_angles_to_dcm_core.sv */
// Euler angles to direction cosine matrix. One angle triple is taken in every
// clock cycle (busy stays low) and its nine Q2.14 entries appear on the rsp_
// ports, marked by rsp_valid for one cycle. Each triple passes through the
// sine/cosine pipeline (17 stages, including six Horner steps of two multiplies
// each), then two 3x3 matrix products of two stages each and a rounding stage.
// The receiver cannot stall; results must be taken when shown. The axis
// registers should be written only while no item is in flight.
module euler_angles_to_dcm_core #(
   parameter int ANGLE_BITS    = eadc_pkg::ANGLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = eadc_pkg::OUT_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [eadc_pkg::FIELD_W-1:0] req_first_angle,
   input  logic signed [eadc_pkg::FIELD_W-1:0] req_second_angle,
   input  logic signed [eadc_pkg::FIELD_W-1:0] req_third_angle,
   output logic                               rsp_valid,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c00,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c01,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c02,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c10,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c11,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c12,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c20,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c21,
   output logic signed [eadc_pkg::OUT_W-1:0]   rsp_c22,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [eadc_pkg::ADDR_W-1:0]         paddr,
   input  logic [eadc_pkg::DATA_W-1:0]         pwdata,
   output logic [eadc_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   localparam int SH = 30 - OUT_FRAC_BITS;
   localparam logic [32:0] HALF = (SH == 0) ? 33'd0 : (33'd1 << (SH - 1));
   localparam int LAT = eadc_pkg::LATENCY;

   logic [1:0] axis_ff [3];
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic           accept;

   eadc_pkg::entry_type sn [3];
   eadc_pkg::entry_type cs [3];
   eadc_pkg::mat_type   e1, e2, e3, m32, mall;
   eadc_pkg::mat_type   r1d_ff [2];

   logic signed [eadc_pkg::OUT_W-1:0] out_ff [9];
   logic signed [eadc_pkg::OUT_W-1:0] out_in [9];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         axis_ff[0] <= eadc_pkg::AXIS_Z;
         axis_ff[1] <= eadc_pkg::AXIS_Y;
         axis_ff[2] <= eadc_pkg::AXIS_X;
      end else begin
         vld_ff <= vld_in;
         if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
               eadc_pkg::REG_FIRST:  axis_ff[0] <= pwdata[1:0];
               eadc_pkg::REG_SECOND: axis_ff[1] <= pwdata[1:0];
               eadc_pkg::REG_THIRD:  axis_ff[2] <= pwdata[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         eadc_pkg::REG_FIRST:  prdata = {30'd0, axis_ff[0]};
         eadc_pkg::REG_SECOND: prdata = {30'd0, axis_ff[1]};
         eadc_pkg::REG_THIRD:  prdata = {30'd0, axis_ff[2]};
         default:              prdata = '0;
      endcase
   end

   eadc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc0 (
      .clock(clock), .angle(req_first_angle), .sin_q(sn[0]), .cos_q(cs[0]));
   eadc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc1 (
      .clock(clock), .angle(req_second_angle), .sin_q(sn[1]), .cos_q(cs[1]));
   eadc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc2 (
      .clock(clock), .angle(req_third_angle), .sin_q(sn[2]), .cos_q(cs[2]));

   assign e1 = eadc_pkg::elem_rot(sn[0], cs[0], axis_ff[0]);
   assign e2 = eadc_pkg::elem_rot(sn[1], cs[1], axis_ff[1]);
   assign e3 = eadc_pkg::elem_rot(sn[2], cs[2], axis_ff[2]);

   // first rotation waits for the third-times-second product
   always_ff @(posedge clock) begin
      r1d_ff[0] <= e1;
      r1d_ff[1] <= r1d_ff[0];
   end

   eadc_matmul u_mul0 (.clock(clock), .a(e3), .b(e2), .p(m32));
   eadc_matmul u_mul1 (.clock(clock), .a(m32), .b(r1d_ff[1]), .p(mall));

   always_comb begin
      for (int n = 0; n < 9; n++) begin
         logic        neg;
         logic [32:0] mag;
         logic [32:0] rnd;
         logic signed [33:0] v;
         neg = mall[n][31];
         mag = neg ? -{mall[n][31], mall[n]} : {mall[n][31], mall[n]};
         rnd = (mag + HALF) >> SH;
         v   = neg ? -{1'b0, rnd} : {1'b0, rnd};
         if (v > 34'sd32767)       out_in[n] = 16'sh7fff;
         else if (v < -34'sd32768) out_in[n] = -16'sh8000;
         else                      out_in[n] = v[15:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 9; n++) out_ff[n] <= out_in[n];
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_c00 = out_ff[0];
   assign rsp_c01 = out_ff[1];
   assign rsp_c02 = out_ff[2];
   assign rsp_c10 = out_ff[3];
   assign rsp_c11 = out_ff[4];
   assign rsp_c12 = out_ff[5];
   assign rsp_c20 = out_ff[6];
   assign rsp_c21 = out_ff[7];
   assign rsp_c22 = out_ff[8];

endmodule

/* hw/rtl/eadc_checker.sv */
`include "euler_angles_to_dcm_core_macros.svh"

module eadc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [eadc_pkg::ADDR_W-1:0]   paddr,
   input logic [eadc_pkg::DATA_W-1:0]   pwdata,
   input logic [eadc_pkg::DATA_W-1:0]   prdata,
   input logic                          pready
);

   `EADC_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
   `EADC_ASSERT_IMPL(a_pready_high, 1'b1, pready)
   `EADC_ASSERT_IMPL(a_result_has_transfer, rsp_valid,
      $past(start && !busy, eadc_pkg::LATENCY))
   `EADC_ASSERT_NEXT(a_axis_readback,
      psel && penable && pwrite && paddr[3:2] == eadc_pkg::REG_FIRST,
      paddr[3:2] != eadc_pkg::REG_FIRST || prdata == {30'd0, $past(pwdata[1:0])})

endmodule

bind euler_angles_to_dcm_core eadc_checker u_checker (.*);

/* tb/tb_top.sv */
module tb_top;

   typedef longint mat9_type [9];
   typedef struct {
      logic [15:0] a1;
      logic [15:0] a2;
      logic [15:0] a3;
   } angles_type;
   typedef struct {
      logic [15:0] e [9];
   } dcm_type;

   // index past the last register, writes to it are dropped
   localparam int UNUSED_REG = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic signed [15:0] req_first_angle = '0;
   logic signed [15:0] req_second_angle = '0;
   logic signed [15:0] req_third_angle = '0;
   logic        rsp_valid;
   logic signed [15:0] rsp_c00, rsp_c01, rsp_c02, rsp_c10, rsp_c11, rsp_c12;
   logic signed [15:0] rsp_c20, rsp_c21, rsp_c22;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [eadc_pkg::ADDR_W-1:0] paddr = '0;
   logic [eadc_pkg::DATA_W-1:0] pwdata = '0;
   logic [eadc_pkg::DATA_W-1:0] prdata;
   logic        pready;

   angles_type pending_angles [$];
   dcm_type    expected_dcm [$];
   logic [1:0] axis1 = eadc_pkg::AXIS_Z, axis2 = eadc_pkg::AXIS_Y, axis3 = eadc_pkg::AXIS_X;
   int unsigned idle_pct = 0;
   int errors = 0;

   euler_angles_to_dcm_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_angle(req_first_angle), .req_second_angle(req_second_angle),
      .req_third_angle(req_third_angle), .rsp_valid(rsp_valid),
      .rsp_c00(rsp_c00), .rsp_c01(rsp_c01), .rsp_c02(rsp_c02),
      .rsp_c10(rsp_c10), .rsp_c11(rsp_c11), .rsp_c12(rsp_c12),
      .rsp_c20(rsp_c20), .rsp_c21(rsp_c21), .rsp_c22(rsp_c22),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic longint round_away(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v < 0) return -((-v + half) >>> s);
      return (v + half) >>> s;
   endfunction

   // sine and cosine in q30 from a binary angle
   function automatic void sin_cos_q30(input logic [15:0] a, output longint sn,
                                       output longint cs);
      logic [31:0] t;
      logic [63:0] r, x, x2, h;
      longint s, c, tmp;
      bit swap;
      int unsigned sdiv [5];
      int unsigned cdiv [6];
      sdiv = '{110, 72, 42, 20, 6};
      cdiv = '{132, 90, 56, 30, 12, 2};
      t = {a, 16'h0000};
      r = 64'(t[29:0]);
      swap = 1'b0;
      if (r > 64'h2000_0000) begin
         r = 64'h4000_0000 - r;
         swap = 1'b1;
      end
      x = (r * 64'd6746518852 + 64'h8000_0000) >> 32;
      x2 = (x * x) >> 30;
      h = 64'h4000_0000;
      for (int i = 0; i < 5; i++) h = 64'h4000_0000 - ((x2 * h) >> 30) / sdiv[i];
      s = longint'((x * h) >> 30);
      h = 64'h4000_0000;
      for (int i = 0; i < 6; i++) h = 64'h4000_0000 - ((x2 * h) >> 30) / cdiv[i];
      c = longint'(h);
      if (swap) begin
         tmp = s; s = c; c = tmp;
      end
      case (t[31:30])
         2'd0: begin sn = s;  cs = c;  end
         2'd1: begin sn = c;  cs = -s; end
         2'd2: begin sn = -s; cs = -c; end
         default: begin sn = -c; cs = s; end
      endcase
   endfunction

   function automatic mat9_type axis_rotation(input logic [15:0] a, input logic [1:0] axis);
      mat9_type m;
      longint s, c, one;
      one = longint'(1) << 30;
      for (int i = 0; i < 9; i++) m[i] = 0;
      sin_cos_q30(a, s, c);
      case (axis)
         eadc_pkg::AXIS_X: begin m[0] = one; m[4] = c; m[8] = c; m[5] = s; m[7] = -s; end
         eadc_pkg::AXIS_Y: begin m[0] = c; m[2] = -s; m[4] = one; m[6] = s; m[8] = c; end
         eadc_pkg::AXIS_Z: begin m[0] = c; m[1] = s; m[3] = -s; m[4] = c; m[8] = one; end
         default: ;
      endcase
      return m;
   endfunction

   function automatic mat9_type q30_product(input mat9_type a, input mat9_type b);
      mat9_type p;
      longint acc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
            p[i*3+j] = round_away(acc, 30);
         end
      return p;
   endfunction

   function automatic dcm_type predict_dcm(input angles_type an);
      mat9_type m;
      dcm_type d;
      longint v;
      m = q30_product(axis_rotation(an.a3, axis3), axis_rotation(an.a2, axis2));
      m = q30_product(m, axis_rotation(an.a1, axis1));
      for (int i = 0; i < 9; i++) begin
         v = round_away(m[i], 16);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         d.e[i] = v[15:0];
      end
      return d;
   endfunction

   // driver: an item is transferred when start is high and busy is low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_dcm.push_back(predict_dcm(pending_angles[0]));
            pending_angles.pop_front();
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_angles.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_first_angle  <= pending_angles[0].a1;
            req_second_angle <= pending_angles[0].a2;
            req_third_angle  <= pending_angles[0].a3;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [15:0] got [9];
      dcm_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_c00, rsp_c01, rsp_c02, rsp_c10, rsp_c11, rsp_c12,
                 rsp_c20, rsp_c21, rsp_c22};
         if (expected_dcm.size() == 0) begin
            $display("%0t: unexpected result c00=%0d", $time, rsp_c00);
            errors++;
         end else begin
            want = expected_dcm.pop_front();
            for (int i = 0; i < 9; i++)
               if (want.e[i] !== got[i]) begin
                  $display("%0t: c%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                           $signed(want.e[i]), $signed(got[i]));
                  errors++;
               end
         end
      end
   end

   task automatic csr_write(input int idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= eadc_pkg::ADDR_W'(4 * idx); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         eadc_pkg::REG_FIRST:  axis1 = val[1:0];
         eadc_pkg::REG_SECOND: axis2 = val[1:0];
         eadc_pkg::REG_THIRD:  axis3 = val[1:0];
         default: ;
      endcase
   endtask

   task automatic add_item(input logic [15:0] a1, input logic [15:0] a2,
                           input logic [15:0] a3);
      angles_type an;
      an.a1 = a1; an.a2 = a2; an.a3 = a3;
      pending_angles.push_back(an);
   endtask

   function automatic logic [15:0] rand_angle();
      // half near quadrant and fold boundaries
      if ($urandom_range(1)) return 16'($urandom);
      return {2'($urandom), 14'($urandom_range(2)) ? 14'h2000 : 14'h0000}
             + 16'($urandom_range(6)) - 16'd3;
   endfunction

   task automatic drain();
      while (pending_angles.size() > 0 || expected_dcm.size() > 0) @(posedge clock);
      repeat (eadc_pkg::LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      logic [15:0] edge_vals [10];
      edge_vals = '{16'h0000, 16'h4000, 16'h8000, 16'h7fff, 16'hffff, 16'h2000,
                    16'h2001, 16'h1fff, 16'h0001, 16'hc000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // reset axis order first
      for (int i = 0; i < 10; i++)
         add_item(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
      add_item(16'h8000, 16'h8000, 16'h8000);
      add_item(16'h7fff, 16'h7fff, 16'h7fff);
      drain();
      csr_write(eadc_pkg::REG_FIRST, 32'd0);
      for (int i = 0; i < 4; i++) add_item(edge_vals[i], edge_vals[i + 1], edge_vals[i + 2]);
      drain();
      for (int ph = 0; ph < 24; ph++) begin
         idle_pct = (ph < 8) ? 12 : (ph < 16) ? 63 : 0;
         case (ph)
            0: begin
               csr_write(eadc_pkg::REG_FIRST, 1);
               csr_write(eadc_pkg::REG_SECOND, 1);
               csr_write(eadc_pkg::REG_THIRD, 1);
            end
            1: begin
               csr_write(eadc_pkg::REG_FIRST, 3);
               csr_write(eadc_pkg::REG_SECOND, 3);
               csr_write(eadc_pkg::REG_THIRD, 3);
            end
            2: begin
               csr_write(eadc_pkg::REG_FIRST, 2);
               csr_write(eadc_pkg::REG_SECOND, 0);
               csr_write(eadc_pkg::REG_THIRD, 2);
               csr_write(UNUSED_REG, 32'hffff_ffff);
            end
            3: begin
               csr_write(eadc_pkg::REG_FIRST, 32'hffff_fffd);
               csr_write(eadc_pkg::REG_SECOND, 2);
               csr_write(eadc_pkg::REG_THIRD, 32'hffff_fffc);
            end
            default: begin
               csr_write(eadc_pkg::REG_FIRST, $urandom);
               csr_write(eadc_pkg::REG_SECOND, $urandom);
               csr_write(eadc_pkg::REG_THIRD, $urandom);
               if ($urandom_range(3) == 0) csr_write(UNUSED_REG, $urandom);
            end
         endcase
         for (int i = 0; i < 60; i++) add_item(rand_angle(), rand_angle(), rand_angle());
         drain();
      end
      if (errors == 0) $display("euler_angles_to_dcm_core: match");
      else $display("euler_angles_to_dcm_core: mismatch");
      $finish;
   end

   initial begin
      #400000;
      $display("euler_angles_to_dcm_core: mismatch");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/eadc_pkg.sv
hw/rtl/eadc_sincos.sv
hw/rtl/eadc_matmul.sv
hw/rtl/euler_angles_to_dcm_core.sv
hw/rtl/eadc_checker.sv
tb/tb_top.sv
